// ===== hw/rtl/assert_macros.svh =====
// assertion macros for the rtl, included by mrg32k3a_step_top.sv
// each macro expects clk and rst_n in scope; compiled out under SYNTHESIS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMP(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error("assertion failed");
`define ASSERT_NXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error("assertion failed");
`else
`define ASSERT_IMP(lbl, ant, con)
`define ASSERT_NXT(lbl, ant, con)
`endif

`endif

// ===== hw/rtl/mrg_pkg.sv =====
// constants and types for the mrg32k3a step pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mrg_pkg;

  localparam int NSTG    = 7;
  localparam int WORD_W  = 32;
  localparam int MUL_W   = 21;
  localparam int FOLD_W  = 15;
  localparam int PROD_W  = WORD_W + MUL_W;
  localparam int FOLD1_W = MUL_W + FOLD_W + 1;
  localparam int FOLD2_W = WORD_W + 1;

  localparam logic [WORD_W-1:0] MOD1 = 32'd4294967087;
  localparam logic [WORD_W-1:0] MOD2 = 32'd4294944443;

  typedef struct packed {
    logic [WORD_W-1:0] modulus;
    logic [FOLD_W-1:0] fold;
    logic [MUL_W-1:0]  mul_pos;
    logic [MUL_W-1:0]  mul_neg;
  } mrg_coef_t;

  // fold is 2^32 mod modulus
  localparam mrg_coef_t COEF1 = '{modulus: MOD1, fold: 15'd209,
                                  mul_pos: 21'd1403580, mul_neg: 21'd810728};
  localparam mrg_coef_t COEF2 = '{modulus: MOD2, fold: 15'd22853,
                                  mul_pos: 21'd527612, mul_neg: 21'd1370589};

  typedef struct packed {
    logic [NSTG:1] load;
    logic [NSTG:1] valid;
  } mrg_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mrg_ctl.sv =====
// valid and per-stage load control for the step pipeline
// depends on mrg_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrg_ctl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  input  wire logic           out_tready,
  output mrg_pkg::mrg_ctl_t   ctl
);

  logic [mrg_pkg::NSTG:1] valid_r;
  logic [mrg_pkg::NSTG:1] valid_nxt;
  logic [mrg_pkg::NSTG:1] ready;

  // a stage loads when empty or when the stage after it moves
  always_comb begin
    ready[mrg_pkg::NSTG] = !valid_r[mrg_pkg::NSTG] || out_tready;
    for (int k = mrg_pkg::NSTG - 1; k >= 1; k--) begin
      ready[k] = !valid_r[k] || ready[k+1];
    end
  end

  always_comb begin
    valid_nxt[1] = ready[1] ? in_tvalid : valid_r[1];
    for (int k = 2; k <= mrg_pkg::NSTG; k++) begin
      valid_nxt[k] = ready[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign ctl = '{load: ready, valid: valid_r};

endmodule

`default_nettype wire

// ===== hw/rtl/mrg_comp.sv =====
// datapath of one recurrence: (mul_pos*a - mul_neg*b) mod modulus, six stages
// depends on mrg_pkg
`timescale 1ns / 1ps
`default_nettype none

module mrg_comp (
  input  wire logic                        clk,
  input  wire mrg_pkg::mrg_ctl_t           ctl,
  input  wire mrg_pkg::mrg_coef_t          coef,
  input  wire logic [mrg_pkg::WORD_W-1:0]  word_pos,
  input  wire logic [mrg_pkg::WORD_W-1:0]  word_neg,
  output logic [mrg_pkg::WORD_W-1:0]       result
);

  localparam int W  = mrg_pkg::WORD_W;
  localparam int PW = mrg_pkg::PROD_W;
  localparam int F1 = mrg_pkg::FOLD1_W;
  localparam int F2 = mrg_pkg::FOLD2_W;

  logic [W-1:0]  ra_r, rb_r, ra_nxt, rb_nxt;
  logic [PW-1:0] pa_r, pb_r, pa_nxt, pb_nxt;
  logic [F1-1:0] fa_r, fb_r, fa_nxt, fb_nxt;
  logic [F2-1:0] ga_r, gb_r, ga_nxt, gb_nxt;
  logic [W-1:0]  sa_r, sb_r, sa_nxt, sb_nxt;
  logic [W-1:0]  p_r, p_nxt;
  logic [W:0]    diff;

  // stage 1: input words below 2*modulus, one conditional subtract
  assign ra_nxt = (word_pos >= coef.modulus) ? word_pos - coef.modulus : word_pos;
  assign rb_nxt = (word_neg >= coef.modulus) ? word_neg - coef.modulus : word_neg;

  // stage 2: products
  assign pa_nxt = PW'(ra_r) * PW'(coef.mul_pos);
  assign pb_nxt = PW'(rb_r) * PW'(coef.mul_neg);

  // stage 3: fold upper bits, 2^32 == fold mod modulus
  assign fa_nxt = F1'(pa_r[PW-1:W]) * F1'(coef.fold) + F1'(pa_r[W-1:0]);
  assign fb_nxt = F1'(pb_r[PW-1:W]) * F1'(coef.fold) + F1'(pb_r[W-1:0]);

  // stage 4: second fold, result below 2*modulus
  assign ga_nxt = F2'(fa_r[F1-1:W]) * F2'(coef.fold) + F2'(fa_r[W-1:0]);
  assign gb_nxt = F2'(fb_r[F1-1:W]) * F2'(coef.fold) + F2'(fb_r[W-1:0]);

  // stage 5: final residues
  assign sa_nxt = (ga_r >= F2'(coef.modulus)) ? W'(ga_r - F2'(coef.modulus))
                                               : ga_r[W-1:0];
  assign sb_nxt = (gb_r >= F2'(coef.modulus)) ? W'(gb_r - F2'(coef.modulus))
                                               : gb_r[W-1:0];

  // stage 6: modular difference
  assign diff  = {1'b0, sa_r} - {1'b0, sb_r};
  assign p_nxt = diff[W] ? diff[W-1:0] + coef.modulus : diff[W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.load[1]) begin
      ra_r <= ra_nxt;
      rb_r <= rb_nxt;
    end
    if (ctl.load[2]) begin
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
    if (ctl.load[3]) begin
      fa_r <= fa_nxt;
      fb_r <= fb_nxt;
    end
    if (ctl.load[4]) begin
      ga_r <= ga_nxt;
      gb_r <= gb_nxt;
    end
    if (ctl.load[5]) begin
      sa_r <= sa_nxt;
      sb_r <= sb_nxt;
    end
    if (ctl.load[6]) begin
      p_r <= p_nxt;
    end
  end

  assign result = p_r;

endmodule

`default_nettype wire

// ===== hw/rtl/mrg32k3a_step_top.sv =====
// mrg32k3a step: stream wrapper, two recurrence datapaths and combine stage
// depends on mrg_pkg, mrg_ctl, mrg_comp and assert_macros.svh
//
// One beat in on the in_ channel carries six seed words; one beat out on the
// out_ channel carries the next word of each component and the combined
// numerator (uniform value = numerator / 4294967088). Seed words at or above
// their modulus are reduced first. No state is kept between beats.
// Pipeline: a beat accepted on in_ passes through seven register stages, the
// first loaded at the accepting edge (reduce, multiply, two folds, residue,
// modular difference, combine), before it is presented on out_tvalid.
// Throughput: one beat per cycle while out_tready is high.
// Each stage loads whenever it is empty or the stage after it moves, so
// bubbles close up while the receiver stalls; in_tready drops only once all
// seven stages hold a beat and out_tready is low. Nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties the pipeline; out_tvalid goes low.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module mrg32k3a_step_top (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // comp1_oldest, comp1_middle, comp1_newest, comp2_oldest, comp2_middle,
  // comp2_newest, 32 bits each from bit 0
  input  wire logic [191:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // uniform_numerator, comp1_next, comp2_next, 32 bits each from bit 0
  output logic [95:0]       out_tdata
);

  localparam int W = mrg_pkg::WORD_W;

  mrg_pkg::mrg_ctl_t ctl;
  logic [W-1:0]      p1, p2;
  logic [W-1:0]      num_r, num_nxt;
  logic [W-1:0]      c1_r, c2_r;

  mrg_ctl u_ctl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .out_tready (out_tready),
    .ctl        (ctl)
  );

  mrg_comp u_comp1 (
    .clk      (clk),
    .ctl      (ctl),
    .coef     (mrg_pkg::COEF1),
    .word_pos (in_tdata[63:32]),
    .word_neg (in_tdata[31:0]),
    .result   (p1)
  );

  mrg_comp u_comp2 (
    .clk      (clk),
    .ctl      (ctl),
    .coef     (mrg_pkg::COEF2),
    .word_pos (in_tdata[191:160]),
    .word_neg (in_tdata[127:96]),
    .result   (p2)
  );

  // equal results take the wrap branch
  assign num_nxt = (p1 > p2) ? p1 - p2 : p1 - p2 + mrg_pkg::MOD1;

  always_ff @(posedge clk) begin
    if (ctl.load[mrg_pkg::NSTG]) begin
      num_r <= num_nxt;
      c1_r  <= p1;
      c2_r  <= p2;
    end
  end

  assign in_tready  = ctl.load[1];
  assign out_tvalid = ctl.valid[mrg_pkg::NSTG];
  assign out_tdata  = {c2_r, c1_r, num_r};

  `ASSERT_IMP(a_full_when_blocked, !in_tready, (&ctl.valid) && !out_tready)
  `ASSERT_NXT(a_accept_enters, in_tvalid && in_tready, ctl.valid[1])
  `ASSERT_IMP(a_next_range, out_tvalid, (c1_r < mrg_pkg::MOD1) && (c2_r < mrg_pkg::MOD2))
  `ASSERT_IMP(a_num_range, out_tvalid, (num_r != '0) && (num_r <= mrg_pkg::MOD1))

endmodule

`default_nettype wire

// ===== verif/tb_mrg32k3a_step_top.sv =====
// self-checking testbench for mrg32k3a_step_top: seed beats in, next words out
// depends on mrg_pkg and the rtl under hw/rtl; predicts each result in plain integer math
`timescale 1ns / 1ps
`default_nettype none

module tb_mrg32k3a_step_top;

  localparam int     WORD_W     = mrg_pkg::WORD_W;
  localparam logic [WORD_W-1:0] MOD1 = mrg_pkg::MOD1;
  localparam logic [WORD_W-1:0] MOD2 = mrg_pkg::MOD2;
  localparam longint MUL_P1_POS = 64'd1403580;
  localparam longint MUL_P1_NEG = 64'd810728;
  localparam longint MUL_P2_POS = 64'd527612;
  localparam longint MUL_P2_NEG = 64'd1370589;
  localparam int     N_RANDOM   = 1835;
  localparam int     HOLD_AT    = 400;
  localparam int     HOLD_LEN   = 300;
  localparam int     CALM_LO    = 900;
  localparam int     CALM_HI    = 1300;
  localparam int     DRAIN_WAIT = 30;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [WORD_W-1:0] c2_newest;
    logic [WORD_W-1:0] c2_middle;
    logic [WORD_W-1:0] c2_oldest;
    logic [WORD_W-1:0] c1_newest;
    logic [WORD_W-1:0] c1_middle;
    logic [WORD_W-1:0] c1_oldest;
  } seed_set_t;

  typedef struct packed {
    logic [WORD_W-1:0] c2_next;
    logic [WORD_W-1:0] c1_next;
    logic [WORD_W-1:0] numerator;
  } mrg_next_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [191:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [95:0]  out_tdata;

  seed_set_t seed_q[$];
  mrg_next_t next_q[$];
  int        n_directed = 0;
  int        accepted_cnt = 0;
  int        checked_cnt = 0;
  int        mismatch_cnt = 0;
  int        hold_left = 0;
  bit        hold_done = 1'b0;
  longint    cycle_cnt = 0;
  logic      calm;

  assign calm = (accepted_cnt >= CALM_LO) && (accepted_cnt < CALM_HI);

  mrg32k3a_step_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint mod_residue(longint x, longint m);
    longint r;
    r = x % m;
    if (r < 0) r += m;
    return r;
  endfunction

  function automatic mrg_next_t mrg_step(seed_set_t s);
    longint    s10, s11, s20, s22, p1, p2;
    mrg_next_t r;
    s10 = s.c1_oldest % MOD1;
    s11 = s.c1_middle % MOD1;
    s20 = s.c2_oldest % MOD2;
    s22 = s.c2_newest % MOD2;
    p1 = mod_residue(MUL_P1_POS * s11 - MUL_P1_NEG * s10, longint'(MOD1));
    p2 = mod_residue(MUL_P2_POS * s22 - MUL_P2_NEG * s20, longint'(MOD2));
    r.c1_next   = p1[WORD_W-1:0];
    r.c2_next   = p2[WORD_W-1:0];
    // equal results take the wrap branch
    if (p1 <= p2) r.numerator = WORD_W'(p1 - p2 + longint'(MOD1));
    else          r.numerator = WORD_W'(p1 - p2);
    return r;
  endfunction

  // mostly full-range words, the rest near the modulus, tiny, near all-ones or zero
  function automatic logic [WORD_W-1:0] seed_word(logic [WORD_W-1:0] m);
    case ($urandom_range(0, 9))
      6:       return m - 32'd4 + WORD_W'($urandom_range(0, 8));
      7:       return WORD_W'($urandom_range(0, 15));
      8:       return 32'hFFFF_FFFF - WORD_W'($urandom_range(0, 7));
      9:       return '0;
      default: return $urandom;
    endcase
  endfunction

  function automatic seed_set_t seeds(logic [WORD_W-1:0] a0, a1, a2, b0, b1, b2);
    seed_set_t s;
    s.c1_oldest = a0;
    s.c1_middle = a1;
    s.c1_newest = a2;
    s.c2_oldest = b0;
    s.c2_middle = b1;
    s.c2_newest = b2;
    return s;
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        next_q.push_back(mrg_step(seed_set_t'(in_tdata)));
        accepted_cnt <= accepted_cnt + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (seed_q.size() != 0 && (calm || $urandom_range(0, 99) >= 6)) begin
          in_tdata  <= seed_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to back up the pipeline
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && accepted_cnt >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= (hold_left == 0) && (calm || $urandom_range(0, 99) >= 6);
    end
  end

  // monitor
  always @(posedge clk) begin
    mrg_next_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = mrg_next_t'(out_tdata);
      if (next_q.size() == 0) begin
        mismatch_cnt <= mismatch_cnt + 1;
        if (mismatch_cnt < 10)
          $display("ERROR: unexpected result beat num=%0d c1=%0d c2=%0d",
                   got.numerator, got.c1_next, got.c2_next);
      end else begin
        want = next_q.pop_front();
        checked_cnt <= checked_cnt + 1;
        if (got.numerator !== want.numerator || got.c1_next !== want.c1_next ||
            got.c2_next !== want.c2_next) begin
          mismatch_cnt <= mismatch_cnt + 1;
          if (mismatch_cnt < 10)
            $display("ERROR: beat %0d num exp %0d got %0d, c1 exp %0d got %0d, c2 exp %0d got %0d",
                     checked_cnt, want.numerator, got.numerator, want.c1_next, got.c1_next,
                     want.c2_next, got.c2_next);
        end
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("ERROR: timeout after %0d cycles", cycle_cnt);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    // extremes, modulus edges, both combine branches, all-zero and equal results
    seed_q.push_back(seeds('0, '0, '0, '0, '0, '0));
    seed_q.push_back(seeds('1, '1, '1, '1, '1, '1));
    seed_q.push_back(seeds(MOD1 - 1, MOD1 - 1, MOD1 - 1, MOD2 - 1, MOD2 - 1, MOD2 - 1));
    seed_q.push_back(seeds(MOD1, MOD1, MOD1, MOD2, MOD2, MOD2));
    seed_q.push_back(seeds(MOD1 + 1, MOD1 + 1, MOD1 + 1, MOD2 + 1, MOD2 + 1, MOD2 + 1));
    seed_q.push_back(seeds('1, '1, '1, '0, '0, '0));
    seed_q.push_back(seeds('0, '0, '0, '1, '1, '1));
    seed_q.push_back(seeds(0, 1, 0, 0, 0, 0));
    seed_q.push_back(seeds(0, 0, 0, 0, 0, 1));
    seed_q.push_back(seeds(1, 0, 0, 0, 0, 0));
    seed_q.push_back(seeds(0, 0, 0, 1, 0, 0));
    seed_q.push_back(seeds(0, 0, '1, 0, '1, 0));
    seed_q.push_back(seeds(MOD1, 1, 0, MOD2, 0, 1));
    seed_q.push_back(seeds(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
    seed_q.push_back(seeds(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                           32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555));
    seed_q.push_back(seeds(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                           32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));
    seed_q.push_back(seeds(MOD1 - 1, 0, 0, 0, 0, MOD2 - 1));
    n_directed = seed_q.size();
    for (int i = 0; i < N_RANDOM; i++)
      seed_q.push_back(seeds(seed_word(MOD1), seed_word(MOD1), seed_word(MOD1),
                             seed_word(MOD2), seed_word(MOD2), seed_word(MOD2)));

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    while (seed_q.size() != 0 || in_tvalid) @(posedge clk);
    while (next_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("%0d seed beats sent (%0d directed, %0d random), %0d results checked",
             accepted_cnt, n_directed, accepted_cnt - n_directed, checked_cnt);
    $display("random stalls both sides, one %0d-cycle receiver hold-off, %0d mismatches",
             HOLD_LEN, mismatch_cnt);
    if (mismatch_cnt == 0 && next_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== mrg32k3a_step_top.f =====
+incdir+hw/rtl
hw/rtl/mrg_pkg.sv
hw/rtl/mrg_ctl.sv
hw/rtl/mrg_comp.sv
hw/rtl/mrg32k3a_step_top.sv
verif/tb_mrg32k3a_step_top.sv
